@@ rtl/dsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrs_pkg
// Types and codes shared by the disk seek request scheduler.
// ----------------------------------------------------------------------------
package dsrs_pkg;

    localparam int unsigned TRACK_W = 16;
    localparam int unsigned IDENT_W = 16;

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_GRANT = 1'b1;

    // status codes
    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // policy codes
    localparam logic [2:0] MODE_FIFO  = 3'd0;
    localparam logic [2:0] MODE_SSTF  = 3'd1;
    localparam logic [2:0] MODE_LOOK  = 3'd2;
    localparam logic [2:0] MODE_CLOOK = 3'd3;
    localparam logic [2:0] MODE_FLOOK = 3'd4;

    // one queue entry as it moves along the row of cells
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [TRACK_W-1:0] track;
        logic               batch;
    } t_entry;

    // input word
    typedef struct packed {
        logic               operation;
        logic [IDENT_W-1:0] request_id;
        logic [TRACK_W-1:0] request_track;
        logic [TRACK_W-1:0] head_position;
    } t_req;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic [IDENT_W-1:0] granted_id;
        logic [TRACK_W-1:0] granted_track;
        logic               sweep_up;
    } t_rsp;

    // control from the sequencer to every cell
    typedef struct packed {
        logic rotate;  // all cells hand their word one place toward the head
        logic drop;    // head cell word is discarded this rotation
    } t_cell_ctl;

endpackage

@@ rtl/dsrs_if.sv @@
// ----------------------------------------------------------------------------
// dsrs_req_if / dsrs_rsp_if / dsrs_cfg_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
interface dsrs_req_if;
    logic            valid;
    logic            ready;
    dsrs_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsrs_rsp_if;
    logic            valid;
    logic            ready;
    dsrs_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dsrs_cell.sv @@
// ----------------------------------------------------------------------------
// dsrs_cell
// One slot of the request row; hands its word to its neighbor on a rotate.
// ----------------------------------------------------------------------------
module dsrs_cell (
    input  logic                i_clk,
    input  dsrs_pkg::t_cell_ctl i_ctl,
    input  dsrs_pkg::t_entry    i_prev,
    output dsrs_pkg::t_entry    o_word
);

    dsrs_pkg::t_entry r_word;

    // shift register stage, no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_word <= i_prev;
        end
    end

    assign o_word = r_word;

endmodule

@@ rtl/disk_seek_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// disk_seek_request_scheduler
// Request queue with FIFO, SSTF, LOOK, CLOOK and FLOOK grant policies.
// ----------------------------------------------------------------------------
// The queue is a circular row of QUEUE_DEPTH cells; the oldest request sits
// in the head cell. Every operation walks the row in passes of QUEUE_DEPTH
// rotations, so the cells are realigned after each pass. An add is one pass
// that drops the new word in at the tail slot. A grant is a batch presence
// pass, one scan pass through the single comparator at the head cell (a
// second pass when LOOK or FLOOK has to reverse), and one removal pass that
// closes the gap behind the chosen entry. A dropped add or a grant on an
// empty queue goes straight to the result. One item is in work at a time; a
// new word is taken only once the previous result has been accepted, or is
// being accepted in the same cycle.
module disk_seek_request_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsrs_req_if.sink   req,
    dsrs_rsp_if.source rsp,
    dsrs_cfg_if.sink   cfg
);

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_PRE, S_SCAN, S_REMOVE, S_OUT
    } t_state;

    t_state                  r_state;
    logic [2:0]              r_mode;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_step;
    logic                    r_active;
    logic                    r_dir;
    logic                    r_any;      // active batch has entries
    logic                    r_op;
    logic [dsrs_pkg::IDENT_W-1:0] r_id;
    logic [dsrs_pkg::TRACK_W-1:0] r_trk;
    logic [dsrs_pkg::TRACK_W-1:0] r_head;
    // scan results
    logic                    r_found;
    logic [IW-1:0]           r_best;
    logic [dsrs_pkg::TRACK_W-1:0] r_best_d;
    logic                    r_up_found;
    logic [IW-1:0]           r_up;
    logic [dsrs_pkg::TRACK_W-1:0] r_up_d;
    logic [IW-1:0]           r_low;
    logic [dsrs_pkg::TRACK_W-1:0] r_low_t;
    logic [IW-1:0]           r_sel;
    dsrs_pkg::t_entry        r_gnt;
    logic                    r_ovalid;
    dsrs_pkg::t_rsp          r_rsp;

    dsrs_pkg::t_cell_ctl     ctl;
    dsrs_pkg::t_entry        w_cell [QUEUE_DEPTH];
    dsrs_pkg::t_entry        head_in;
    dsrs_pkg::t_entry        w_head;

    assign w_head = w_cell[0];

    // row of cells; the tail cell is fed from the head cell, a new word or the cell behind the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dsrs_pkg::t_entry w_prev;
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_prev = head_in;
        end else begin : g_mid
            assign w_prev = w_cell[g + 1];
        end
        dsrs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_prev (w_prev),
            .o_word (w_cell[g])
        );
    end

    wire [IW-1:0] pos = r_step[IW-1:0];
    wire [CW-1:0] pos_c = r_step;
    wire in_q = pos_c < r_count;
    wire [dsrs_pkg::TRACK_W-1:0] t = w_head.track;
    wire [dsrs_pkg::TRACK_W-1:0] d_abs = (t >= r_head) ? t - r_head : r_head - t;
    wire is_flook = r_mode == dsrs_pkg::MODE_FLOOK;
    wire is_look = r_mode == dsrs_pkg::MODE_LOOK || is_flook;
    wire elig = in_q && (!is_flook || w_head.batch == r_active) &&
                (r_dir ? t >= r_head : t <= r_head);

    // tail cell input: recirculated head word, a new word, or the head's successor to close the gap
    always_comb begin
        head_in = w_head;
        ctl.rotate = 1'b0;
        ctl.drop = 1'b0;
        case (r_state)
            S_ADD: begin
                ctl.rotate = 1'b1;
                if (pos_c == r_count) begin
                    head_in.ident = r_id;
                    head_in.track = r_trk;
                    head_in.batch = ~r_active;
                end
            end
            S_PRE, S_SCAN: ctl.rotate = 1'b1;
            S_REMOVE: begin
                ctl.rotate = 1'b1;
                ctl.drop = pos == r_sel;
                // from the chosen slot on, each slot takes its successor
                if (pos >= r_sel) head_in = w_cell[1];
            end
            default: ;
        endcase
    end

    assign req.ready = r_state == S_IDLE && (!r_ovalid || rsp.ready);
    assign cfg.ready = r_state == S_IDLE;

    // sequencer; every pass is QUEUE_DEPTH rotations so cells realign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= dsrs_pkg::MODE_FIFO;
            r_count  <= '0;
            r_active <= 1'b0;
            r_dir    <= 1'b1;
            r_ovalid <= 1'b0;
            r_step   <= '0;
        end else begin
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (cfg.valid) r_mode <= cfg.data;
                    if (req.valid && req.ready) begin
                        r_op   <= req.data.operation;
                        r_id   <= req.data.request_id;
                        r_trk  <= req.data.request_track;
                        r_head <= req.data.head_position;
                        r_step <= '0;
                        r_any  <= 1'b0;
                        r_found <= 1'b0;
                        r_up_found <= 1'b0;
                        if (req.data.operation == dsrs_pkg::OP_ADD) begin
                            if (r_count == DEPTH_C) begin
                                r_rsp <= '{dsrs_pkg::ST_FULL, '0, '0, r_dir};
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end else if (r_count == '0) begin
                            r_rsp <= '{dsrs_pkg::ST_EMPTY, '0, '0, r_dir};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PRE;
                        end
                    end
                end
                S_ADD: begin
                    // the cell written at step==count lands at slot count
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_C) begin
                        r_count <= r_count + 1'b1;
                        r_rsp <= '{dsrs_pkg::ST_ADDED, '0, '0, r_dir};
                        r_state <= S_OUT;
                    end
                end
                S_PRE: begin
                    // batch presence pass
                    if (in_q && w_head.batch == r_active) r_any <= 1'b1;
                    r_step <= (r_step == LAST_C) ? '0 : r_step + 1'b1;
                    if (r_step == LAST_C) begin
                        if (is_flook && !(r_any ||
                            (in_q && w_head.batch == r_active)))
                            r_active <= ~r_active;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // LOOK/FLOOK nearest eligible, SSTF nearest overall, CLOOK next up else lowest
                    if (is_look) begin
                        if (elig && (!r_found ||
                            (r_dir ? t - r_head : r_head - t) < r_best_d)) begin
                            r_found  <= 1'b1;
                            r_best   <= pos;
                            r_best_d <= r_dir ? t - r_head : r_head - t;
                        end
                    end else if (r_mode == dsrs_pkg::MODE_SSTF) begin
                        if (in_q && (pos == '0 || d_abs < r_best_d)) begin
                            r_best   <= pos;
                            r_best_d <= d_abs;
                        end
                    end
                    if (in_q && t >= r_head && (!r_up_found || t - r_head < r_up_d)) begin
                        r_up_found <= 1'b1;
                        r_up <= pos;
                        r_up_d <= t - r_head;
                    end
                    if (in_q && (pos == '0 || t < r_low_t)) begin
                        r_low <= pos;
                        r_low_t <= t;
                    end
                    r_step <= (r_step == LAST_C) ? '0 : r_step + 1'b1;
                    if (r_step == LAST_C) begin
                        if (is_look && !r_found && !elig) begin
                            r_dir <= ~r_dir;   // reverse and scan again
                        end else begin
                            case (r_mode)
                                dsrs_pkg::MODE_SSTF:
                                    r_sel <= (in_q && d_abs < r_best_d) ? pos : r_best;
                                dsrs_pkg::MODE_LOOK, dsrs_pkg::MODE_FLOOK:
                                    r_sel <= (elig && (!r_found ||
                                        (r_dir ? t - r_head : r_head - t) < r_best_d))
                                        ? pos : r_best;
                                dsrs_pkg::MODE_CLOOK:
                                    if (in_q && t >= r_head &&
                                        (!r_up_found || t - r_head < r_up_d))
                                        r_sel <= pos;
                                    else if (r_up_found)
                                        r_sel <= r_up;
                                    else if (in_q && t < r_low_t)
                                        r_sel <= pos;
                                    else
                                        r_sel <= r_low;
                                default: r_sel <= '0;
                            endcase
                            r_state <= S_REMOVE;
                        end
                    end
                end
                S_REMOVE: begin
                    if (ctl.drop) r_gnt <= w_head;
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_C) begin
                        r_count <= r_count - 1'b1;
                        r_rsp <= '{dsrs_pkg::ST_GRANTED,
                                   ctl.drop ? w_head.ident : r_gnt.ident,
                                   ctl.drop ? w_head.track : r_gnt.track, r_dir};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid = r_ovalid;
    assign rsp.data  = r_rsp;

endmodule

@@ rtl/dsrs_check.sv @@
// ----------------------------------------------------------------------------
// dsrs_check
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module dsrs_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input dsrs_pkg::t_rsp rsp_data
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed under stall");

    // no new word accepted right after one
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word accepted while busy");

    // non-grant results carry zero id and track
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.status != dsrs_pkg::ST_GRANTED |->
        rsp_data.granted_id == '0 && rsp_data.granted_track == '0)
        else $error("payload on non-grant result");

endmodule

bind disk_seek_request_scheduler dsrs_check u_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
